### sv/voice_session_phase_controller_unit_defines.svh
// Assertion macros shared by the voice session phase controller.
`ifndef VOICE_SESSION_PHASE_CONTROLLER_UNIT_DEFINES_SVH
`define VOICE_SESSION_PHASE_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VSPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("vspc same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define VSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("vspc next-cycle check failed");

`endif

### sv/vspc_pkg.sv
// Types, codes and helpers of the voice session phase controller.
package vspc_pkg;

  localparam int unsigned EPOCH_BITS = 16;
  localparam int unsigned OUT_EPOCH_W = 16;

  typedef logic [EPOCH_BITS-1:0] epoch_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START  = 4'd1,
    PH_LISTEN = 4'd2,
    PH_THINK  = 4'd3,
    PH_SYNTH  = 4'd4,
    PH_QUEUED = 4'd5,
    PH_PLAY   = 4'd6,
    PH_DRAIN  = 4'd7,
    PH_FOLLOW = 4'd8,
    PH_CANCEL = 4'd9,
    PH_ERROR  = 4'd10
  } phase_e;

  typedef enum logic [3:0] {
    EV_WAKE        = 4'd0,
    EV_START_ACK   = 4'd1,
    EV_LISTENING   = 4'd2,
    EV_THINKING    = 4'd3,
    EV_SYNTH_START = 4'd4,
    EV_URL_ACCEPT  = 4'd5,
    EV_URL_REJECT  = 4'd6,
    EV_RUN_END     = 4'd7,
    EV_ERROR       = 4'd8,
    EV_SRC_PLAY    = 4'd9,
    EV_SRC_DONE    = 4'd10,
    EV_DRAINED     = 4'd11,
    EV_BARGE_READY = 4'd12,
    EV_OBSERVED    = 4'd13
  } event_e;

  // Effect bit positions.
  localparam int unsigned FX_W          = 7;
  localparam int unsigned FX_START      = 0;
  localparam int unsigned FX_STOP       = 1;
  localparam int unsigned FX_STOP_PATH  = 2;
  localparam int unsigned FX_PROXY_IDLE = 3;
  localparam int unsigned FX_ANNOUNCE   = 4;
  localparam int unsigned FX_START_CUR  = 5;
  localparam int unsigned FX_REJECT     = 6;

  // Busy mask bit positions.
  localparam int unsigned MB_MEDIA     = 0;
  localparam int unsigned MB_ANNC      = 1;
  localparam int unsigned MB_TIMER     = 2;
  localparam int unsigned MB_IC_RING   = 3;
  localparam int unsigned MB_IC_OUT    = 4;
  localparam int unsigned MB_IC_STREAM = 5;
  localparam int unsigned MB_START     = 6;
  localparam int unsigned MB_LISTEN    = 7;
  localparam int unsigned MB_THINK     = 8;
  localparam int unsigned MB_SYNTH     = 9;
  localparam int unsigned MB_QUEUED    = 10;
  localparam int unsigned MB_PLAY      = 11;
  localparam int unsigned MB_DRAIN     = 12;
  localparam int unsigned MB_FOLLOW    = 13;
  localparam int unsigned MB_BARGE     = 14;
  localparam int unsigned MB_ERROR     = 15;

  typedef enum logic [1:0] {
    IC_OTHER  = 2'd0,
    IC_RING   = 2'd1,
    IC_OUT    = 2'd2,
    IC_STREAM = 2'd3
  } icom_e;

  typedef enum logic [3:0] {
    LED_IDLE      = 4'd0,
    LED_BOTH_MUTE = 4'd1,
    LED_MIC_MUTE  = 4'd2,
    LED_SPK_MUTE  = 4'd3,
    LED_WAKE      = 4'd4,
    LED_LISTEN    = 4'd5,
    LED_THINK     = 4'd6,
    LED_RESPOND   = 4'd7,
    LED_IC_RING   = 4'd8,
    LED_IC_OUT    = 4'd9,
    LED_IC_STREAM = 4'd10,
    LED_ERROR     = 4'd11,
    LED_MEDIA     = 4'd12,
    LED_INIT      = 4'd13,
    LED_NO_WIFI   = 4'd14,
    LED_NO_HA     = 4'd15
  } led_e;

  typedef enum logic [2:0] {
    CP_OTHER   = 3'd0,
    CP_LISTEN  = 3'd1,
    CP_THINK   = 3'd2,
    CP_RESPOND = 3'd3,
    CP_ERROR   = 3'd4
  } compat_e;

  // Observed device status carried with each word.
  typedef struct packed {
    logic       proxy;
    logic       va_run;
    logic       media;
    logic       annc;
    logic       timer;
    icom_e      icom;
    logic       init;
    logic       no_wifi;
    logic       no_ha;
    logic [1:0] mute;
  } obs_t;

  // Session state after one event, plus the effects it raised.
  typedef struct packed {
    logic [FX_W-1:0] fx;
    phase_e          phase;
    epoch_t          act;
    epoch_t          reply;
    epoch_t          prop;
    logic            barge;
    logic            cur_url;
    logic            que_url;
    logic            run_end;
  } sess_t;

  typedef struct packed {
    logic [15:0] mask;
    led_e        led;
    compat_e     compat;
  } status_t;

  function automatic logic is_barge_ph(phase_e p);
    return (p == PH_SYNTH) || (p == PH_QUEUED) || (p == PH_PLAY) || (p == PH_DRAIN);
  endfunction

  function automatic logic is_resp_ph(phase_e p);
    return is_barge_ph(p) || (p == PH_FOLLOW);
  endfunction

  function automatic epoch_t next_epoch(epoch_t e);
    return e + epoch_t'(1);
  endfunction

  function automatic logic [OUT_EPOCH_W-1:0] epoch_out(epoch_t e);
    return OUT_EPOCH_W'(e);
  endfunction

endpackage

### sv/vspc_core.sv
// Session state registers and the per-event transition rules.
module vspc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  vspc_pkg::event_e ev_i,
  input  logic             enq_i,
  input  logic             proxy_i,
  input  logic             va_run_i,
  output vspc_pkg::sess_t  next_o
);
  import vspc_pkg::*;

  phase_e ph_q;
  epoch_t act_q, reply_q, prop_q;
  logic   barge_q, cur_q, que_q, run_end_q;
  sess_t  nx;

  always_comb begin
    nx.fx      = '0;
    nx.phase   = ph_q;
    nx.act     = act_q;
    nx.reply   = reply_q;
    nx.prop    = prop_q;
    nx.barge   = barge_q;
    nx.cur_url = cur_q;
    nx.que_url = que_q;
    nx.run_end = run_end_q;
    case (ev_i)
      EV_WAKE: begin
        if (ph_q == PH_IDLE || ph_q == PH_FOLLOW) begin
          nx.prop              = next_epoch(act_q);
          nx.phase             = PH_START;
          nx.run_end           = 1'b0;
          nx.fx[FX_START]      = 1'b1;
        end else if (is_barge_ph(ph_q) || proxy_i) begin
          nx.phase             = PH_CANCEL;
          nx.barge             = 1'b1;
          nx.fx[FX_STOP]       = 1'b1;
          nx.fx[FX_STOP_PATH]  = 1'b1;
          nx.fx[FX_PROXY_IDLE] = 1'b1;
        end
      end
      EV_START_ACK: begin
        // A zero proposal means none was made.
        if (prop_q != '0) begin
          nx.act = prop_q;
        end else if (ph_q == PH_IDLE || ph_q == PH_FOLLOW) begin
          nx.act = next_epoch(act_q);
        end
        nx.prop    = '0;
        nx.phase   = PH_START;
        nx.run_end = 1'b0;
      end
      EV_LISTENING: begin
        if (ph_q != PH_CANCEL) begin
          nx.phase   = PH_LISTEN;
          nx.run_end = 1'b0;
        end
      end
      EV_THINKING: begin
        if (ph_q == PH_LISTEN || ph_q == PH_START) begin
          nx.phase = PH_THINK;
        end
      end
      EV_SYNTH_START: begin
        if (ph_q != PH_CANCEL) begin
          nx.reply = act_q;
          nx.phase = PH_SYNTH;
        end
      end
      EV_URL_ACCEPT: begin
        if (ph_q == PH_SYNTH || ph_q == PH_THINK) begin
          nx.reply            = act_q;
          nx.phase            = PH_QUEUED;
          nx.cur_url          = 1'b1;
          nx.fx[FX_ANNOUNCE]  = 1'b1;
          nx.fx[FX_START_CUR] = 1'b1;
        end else if (is_resp_ph(ph_q) && enq_i) begin
          nx.que_url = 1'b1;
        end else begin
          nx.fx[FX_REJECT] = 1'b1;
        end
      end
      EV_URL_REJECT: begin
        nx.fx[FX_REJECT] = 1'b1;
      end
      EV_RUN_END: begin
        nx.run_end = 1'b1;
        if (!va_run_i &&
            (ph_q == PH_FOLLOW || (!is_resp_ph(ph_q) && ph_q != PH_CANCEL))) begin
          nx.phase = PH_IDLE;
        end
      end
      EV_ERROR: begin
        nx.phase             = PH_ERROR;
        nx.barge             = 1'b0;
        nx.fx[FX_PROXY_IDLE] = 1'b1;
        nx.fx[FX_STOP_PATH]  = 1'b1;
      end
      EV_SRC_PLAY: begin
        if (ph_q == PH_QUEUED || ph_q == PH_SYNTH) begin
          nx.phase = PH_PLAY;
        end else if (ph_q == PH_CANCEL) begin
          nx.fx[FX_STOP_PATH] = 1'b1;
        end
      end
      EV_SRC_DONE: begin
        if (ph_q == PH_QUEUED || ph_q == PH_PLAY || ph_q == PH_SYNTH) begin
          if (que_q) begin
            // Advance to the queued URL.
            nx.que_url          = 1'b0;
            nx.phase            = PH_QUEUED;
            nx.fx[FX_START_CUR] = 1'b1;
          end else begin
            nx.phase   = PH_DRAIN;
            nx.cur_url = 1'b0;
          end
        end
      end
      EV_DRAINED: begin
        if (ph_q == PH_DRAIN) begin
          nx.reply             = '0;
          nx.cur_url           = 1'b0;
          nx.que_url           = 1'b0;
          nx.fx[FX_PROXY_IDLE] = 1'b1;
          nx.phase             = barge_q ? PH_CANCEL : PH_FOLLOW;
        end
      end
      EV_BARGE_READY: begin
        if (ph_q == PH_CANCEL && barge_q) begin
          nx.prop         = next_epoch(act_q);
          nx.barge        = 1'b0;
          nx.reply        = '0;
          nx.cur_url      = 1'b0;
          nx.que_url      = 1'b0;
          nx.phase        = PH_START;
          nx.fx[FX_START] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PH_IDLE;
      act_q     <= '0;
      reply_q   <= '0;
      prop_q    <= '0;
      barge_q   <= 1'b0;
      cur_q     <= 1'b0;
      que_q     <= 1'b0;
      run_end_q <= 1'b0;
    end else if (step_i) begin
      ph_q      <= nx.phase;
      act_q     <= nx.act;
      reply_q   <= nx.reply;
      prop_q    <= nx.prop;
      barge_q   <= nx.barge;
      cur_q     <= nx.cur_url;
      que_q     <= nx.que_url;
      run_end_q <= nx.run_end;
    end
  end

  assign next_o = nx;

endmodule

### sv/vspc_status.sv
// Busy mask, indicator priority and compatibility state from the new phase.
module vspc_status (
  input  vspc_pkg::phase_e  phase_i,
  input  logic              barge_i,
  input  vspc_pkg::obs_t    obs_i,
  output vspc_pkg::status_t status_o
);
  import vspc_pkg::*;

  logic [15:0] m;
  led_e        led;
  compat_e     cp;

  always_comb begin
    m               = '0;
    m[MB_MEDIA]     = obs_i.media;
    m[MB_ANNC]      = obs_i.annc;
    m[MB_TIMER]     = obs_i.timer;
    m[MB_IC_RING]   = (obs_i.icom == IC_RING);
    m[MB_IC_OUT]    = (obs_i.icom == IC_OUT);
    m[MB_IC_STREAM] = (obs_i.icom == IC_STREAM);
    case (phase_i)
      PH_START:  m[MB_START]  = 1'b1;
      PH_LISTEN: m[MB_LISTEN] = 1'b1;
      PH_THINK:  m[MB_THINK]  = 1'b1;
      PH_SYNTH:  m[MB_SYNTH]  = 1'b1;
      PH_QUEUED: m[MB_QUEUED] = 1'b1;
      PH_PLAY:   m[MB_PLAY]   = 1'b1;
      PH_DRAIN:  m[MB_DRAIN]  = 1'b1;
      PH_FOLLOW: m[MB_FOLLOW] = 1'b1;
      PH_CANCEL: m[MB_BARGE]  = 1'b1;
      PH_ERROR:  m[MB_ERROR]  = 1'b1;
      default: begin
      end
    endcase
    // Cancel phase and a pending barge-in share one bit.
    if (barge_i) begin
      m[MB_BARGE] = 1'b1;
    end
  end

  always_comb begin
    if (obs_i.init) begin
      led = LED_INIT;
    end else if (obs_i.no_wifi) begin
      led = LED_NO_WIFI;
    end else if (obs_i.no_ha) begin
      led = LED_NO_HA;
    end else if (obs_i.mute[0] && obs_i.mute[1]) begin
      led = LED_BOTH_MUTE;
    end else if (obs_i.mute[0]) begin
      led = LED_MIC_MUTE;
    end else if (obs_i.mute[1]) begin
      led = LED_SPK_MUTE;
    end else if (m[MB_BARGE] || m[MB_START]) begin
      led = LED_WAKE;
    end else if (m[MB_LISTEN]) begin
      led = LED_LISTEN;
    end else if (m[MB_THINK] || m[MB_SYNTH]) begin
      led = LED_THINK;
    end else if (m[MB_QUEUED] || m[MB_PLAY] || m[MB_DRAIN] || m[MB_FOLLOW]) begin
      led = LED_RESPOND;
    end else if (m[MB_IC_RING]) begin
      led = LED_IC_RING;
    end else if (m[MB_IC_OUT]) begin
      led = LED_IC_OUT;
    end else if (m[MB_IC_STREAM]) begin
      led = LED_IC_STREAM;
    end else if (m[MB_ERROR]) begin
      led = LED_ERROR;
    end else if (m[MB_MEDIA] || m[MB_ANNC] || m[MB_TIMER]) begin
      led = LED_MEDIA;
    end else begin
      led = LED_IDLE;
    end
  end

  always_comb begin
    if (phase_i == PH_LISTEN) begin
      cp = CP_LISTEN;
    end else if (phase_i == PH_THINK) begin
      cp = CP_THINK;
    end else if (is_resp_ph(phase_i)) begin
      cp = CP_RESPOND;
    end else if (phase_i == PH_ERROR) begin
      cp = CP_ERROR;
    end else begin
      cp = CP_OTHER;
    end
  end

  assign status_o.mask   = m;
  assign status_o.led    = led;
  assign status_o.compat = cp;

endmodule

### sv/voice_session_phase_controller_unit.sv
// Voice session phase controller: input register, transition logic, result register.
//
// One event word enters on the s_axis channel: tuser carries the event code,
// tdata the enqueue flag and the observed device status. For each word one
// result word leaves on the m_axis channel with the effects mask, the new
// phase, the busy mask, the indicator code, the compatibility state, the
// three epochs and the session flags.
// Flow: a taken word is held in the input register, runs through the transition
// logic and lands in the result register, which drives m_axis_tvalid.
// Throughput: one word per cycle while the receiver keeps m_axis_tready high;
// the session state registers close a loop around the transition logic.
// Reset clears the phase to idle, all epochs and flags, and both valid bits.
// When the receiver holds m_axis_tready low the result stays put, one more
// word may wait in the input register, and s_axis_tready then drops until
// the result is taken.
`include "voice_session_phase_controller_unit_defines.svh"

module voice_session_phase_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] enqueue, [1] proxy announce, [2] assistant run, [3] media on,
  // [4] announcement on, [5] timer alarm, [7:6] intercom_phase,
  // [8] initializing, [9] no_wifi, [10] no_ha, [12:11] mute_flags, [15:13] zero
  input  logic [15:0] s_axis_tdata,
  // [3:0] event_code
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] effects, [10:7] phase, [26:11] busy mask, [30:27] indicator_code,
  // [33:31] compat_state, [49:34] session_epoch, [65:50] speech_epoch,
  // [81:66] pending_epoch, [82] barge_flag, [83] current_url_flag,
  // [84] queued_url_flag, [85] run_ended_flag, [87:86] zero
  output logic [87:0] m_axis_tdata
);
  import vspc_pkg::*;

  logic        in_vld_q;
  event_e      ev_q;
  logic        enq_q;
  obs_t        obs_q;
  logic        out_vld_q;
  logic [87:0] out_q;
  logic        adv;
  logic        take;
  sess_t       nx;
  status_t     st;
  obs_t        obs_in;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign take          = s_axis_tvalid && s_axis_tready;

  assign obs_in.proxy   = s_axis_tdata[1];
  assign obs_in.va_run  = s_axis_tdata[2];
  assign obs_in.media   = s_axis_tdata[3];
  assign obs_in.annc    = s_axis_tdata[4];
  assign obs_in.timer   = s_axis_tdata[5];
  assign obs_in.icom    = icom_e'(s_axis_tdata[7:6]);
  assign obs_in.init    = s_axis_tdata[8];
  assign obs_in.no_wifi = s_axis_tdata[9];
  assign obs_in.no_ha   = s_axis_tdata[10];
  assign obs_in.mute    = s_axis_tdata[12:11];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold the input word until it advances.
  always_ff @(posedge clk_i) begin
    if (take) begin
      ev_q  <= event_e'(s_axis_tuser);
      enq_q <= s_axis_tdata[0];
      obs_q <= obs_in;
    end
    if (adv) begin
      out_q <= {2'b00, nx.run_end, nx.que_url, nx.cur_url, nx.barge,
                epoch_out(nx.prop), epoch_out(nx.reply), epoch_out(nx.act),
                st.compat, st.led, st.mask, nx.phase, nx.fx};
    end
  end

  vspc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .ev_i     (ev_q),
    .enq_i    (enq_q),
    .proxy_i  (obs_q.proxy),
    .va_run_i (obs_q.va_run),
    .next_o   (nx)
  );

  vspc_status u_status (
    .phase_i  (nx.phase),
    .barge_i  (nx.barge),
    .obs_i    (obs_q),
    .status_o (st)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  `VSPC_ASSERT_NEXT(a_adv_fills_out, clk_i, rst_ni, adv, out_vld_q)
  `VSPC_ASSERT_NOW(a_busy_blocks_in, clk_i, rst_ni, in_vld_q && !adv, !s_axis_tready)
  `VSPC_ASSERT_NOW(a_barge_in_mask, clk_i, rst_ni, out_vld_q && out_q[82], out_q[25])

endmodule
